@@ sv/assert_macros.svh @@
// Assertion macros for the scc_core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SCC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("scc assertion failed");

// Checks that expr holds in the cycle after cond.
`define SCC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("scc next-cycle assertion failed");

`endif

@@ sv/scc_pkg.sv @@
package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int EIDX_W    = $clog2(MAX_EDGES);
    localparam int EDGE_W    = EIDX_W + 1;

    localparam logic [EDGE_W-1:0] NO_EDGE = EDGE_W'(MAX_EDGES);

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_COMP  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_NOCOMP = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NODE_W-1:0] first_node;
        logic [NODE_W-1:0] second_node;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             same_component;
        logic [CNT_W-1:0] first_component;
        logic [CNT_W-1:0] second_component;
        logic [CNT_W-1:0] component_count;
    } out_t;

    typedef struct packed {
        logic [EDGE_W-1:0] first;
        logic [EDGE_W-1:0] last;
    } head_t;

    typedef struct packed {
        logic             visited;
        logic             onstk;
        logic [CNT_W-1:0] visit;
        logic [CNT_W-1:0] comp;
    } info_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [EDGE_W-1:0] edge_ptr;
        logic [CNT_W-1:0]  low;
        logic [CNT_W-1:0]  visit;
    } frame_t;

endpackage

@@ sv/scc_ram.sv @@
module scc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/scc_core.sv @@
`include "assert_macros.svh"

module scc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [scc_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  scc_pkg::in_t                s_data,
    input  logic                        out_free,
    output logic                        res_valid,
    output scc_pkg::out_t               res_data
);
    import scc_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ADD1, S_ADD2, S_Q1, S_Q2, S_CLR, S_ROOT, S_ROOTW,
        S_ENTER, S_ENTER1, S_LOOP, S_EDGE1, S_EDGE2, S_RET, S_CLOSE0,
        S_CLOSE1, S_POP, S_POP1, S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  nc_reg, nc_next;
    logic [EDGE_W-1:0] edges_reg, edges_next;
    logic [CNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]  ccnt_reg, ccnt_next;
    logic              rv_reg, rv_next;
    logic [CNT_W-1:0]  pt_reg, pt_next;
    logic [CNT_W-1:0]  ft_reg, ft_next;
    logic [NODE_W-1:0] v_reg, v_next;
    logic [EDGE_W-1:0] e_reg, e_next;
    logic [CNT_W-1:0]  vlow_reg, vlow_next;
    logic [CNT_W-1:0]  vvis_reg, vvis_next;
    logic [NODE_W-1:0] n_reg, n_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [1:0]        status_reg, status_next;
    logic              same_reg, same_next;
    logic [CNT_W-1:0]  ca_reg, ca_next;
    logic [CNT_W-1:0]  cb_reg, cb_next;
    logic [CNT_W-1:0]  vc1;

    logic              head_we;
    logic [NODE_W-1:0] head_waddr, head_raddr;
    head_t             head_wdata, head_rdata;
    logic              info_we;
    logic [NODE_W-1:0] info_waddr, info_raddr;
    info_t             info_wdata, info_rdata;
    logic              tgt_we;
    logic [EIDX_W-1:0] tgt_waddr, tgt_raddr;
    logic [NODE_W-1:0] tgt_wdata, tgt_rdata;
    logic              link_we;
    logic [EIDX_W-1:0] link_waddr, link_raddr;
    logic [EDGE_W-1:0] link_wdata, link_rdata;
    logic              pend_we;
    logic [NODE_W-1:0] pend_waddr, pend_raddr;
    logic [NODE_W-1:0] pend_wdata, pend_rdata;
    logic              frame_we;
    logic [NODE_W-1:0] frame_waddr, frame_raddr;
    frame_t            frame_wdata, frame_rdata;

    scc_ram #(.W($bits(head_t)), .D(MAX_NODES)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    scc_ram #(.W($bits(info_t)), .D(MAX_NODES)) u_info (
        .aclk(aclk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata));
    scc_ram #(.W(NODE_W), .D(MAX_EDGES)) u_tgt (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .raddr(tgt_raddr), .rdata(tgt_rdata));
    scc_ram #(.W(EDGE_W), .D(MAX_EDGES)) u_link (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata));
    scc_ram #(.W(NODE_W), .D(MAX_NODES)) u_pend (
        .aclk(aclk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
        .raddr(pend_raddr), .rdata(pend_rdata));
    scc_ram #(.W($bits(frame_t)), .D(MAX_NODES)) u_frame (
        .aclk(aclk), .we(frame_we), .waddr(frame_waddr), .wdata(frame_wdata),
        .raddr(frame_raddr), .rdata(frame_rdata));

    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign res_valid = (state_reg == S_RESP);
    assign vc1       = vcnt_reg + CNT_W'(1);

    always_comb begin
        res_data.status           = status_reg;
        res_data.same_component   = same_reg;
        res_data.first_component  = ca_reg;
        res_data.second_component = cb_reg;
        res_data.component_count  = rv_reg ? ccnt_reg : '0;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        nc_next     = nc_reg;
        edges_next  = edges_reg;
        vcnt_next   = vcnt_reg;
        ccnt_next   = ccnt_reg;
        rv_next     = rv_reg;
        pt_next     = pt_reg;
        ft_next     = ft_reg;
        v_next      = v_reg;
        e_next      = e_reg;
        vlow_next   = vlow_reg;
        vvis_next   = vvis_reg;
        n_next      = n_reg;
        b_next      = b_reg;
        status_next = status_reg;
        same_next   = same_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;

        head_we = 1'b0;  head_waddr = '0;  head_wdata = '0;  head_raddr = '0;
        info_we = 1'b0;  info_waddr = '0;  info_wdata = '0;  info_raddr = '0;
        tgt_we = 1'b0;   tgt_waddr = '0;   tgt_wdata = '0;   tgt_raddr = '0;
        link_we = 1'b0;  link_waddr = '0;  link_wdata = '0;  link_raddr = '0;
        pend_we = 1'b0;  pend_waddr = '0;  pend_wdata = '0;  pend_raddr = '0;
        frame_we = 1'b0; frame_waddr = '0; frame_wdata = '0; frame_raddr = '0;

        case (state_reg)
            S_INIT: begin
                head_we    = 1'b1;
                head_waddr = idx_reg[NODE_W-1:0];
                head_wdata = '{first: NO_EDGE, last: NO_EDGE};
                idx_next   = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(MAX_NODES - 1)) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    n_next      = s_data.first_node;
                    b_next      = s_data.second_node;
                    status_next = ST_OK;
                    same_next   = 1'b0;
                    ca_next     = '0;
                    cb_next     = '0;
                    state_next  = S_RESP;
                    case (s_data.mode)
                        MODE_ADD: begin
                            if ({1'b0, s_data.first_node} >= nc_reg ||
                                {1'b0, s_data.second_node} >= nc_reg) begin
                                status_next = ST_RANGE;
                            end else if (edges_reg == NO_EDGE) begin
                                status_next = ST_FULL;
                            end else begin
                                head_raddr = s_data.first_node;
                                state_next = S_ADD1;
                            end
                        end
                        MODE_COMP: begin
                            idx_next   = '0;
                            state_next = S_CLR;
                        end
                        MODE_QUERY: begin
                            if (!rv_reg) begin
                                status_next = ST_NOCOMP;
                            end else if ({1'b0, s_data.first_node} >= nc_reg ||
                                         {1'b0, s_data.second_node} >= nc_reg) begin
                                status_next = ST_RANGE;
                            end else begin
                                info_raddr = s_data.first_node;
                                state_next = S_Q1;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD1: begin
                tgt_we     = 1'b1;
                tgt_waddr  = edges_reg[EIDX_W-1:0];
                tgt_wdata  = b_reg;
                link_we    = 1'b1;
                link_waddr = edges_reg[EIDX_W-1:0];
                link_wdata = NO_EDGE;
                head_we    = 1'b1;
                head_waddr = n_reg;
                head_wdata.first = (head_rdata.last == NO_EDGE) ? edges_reg : head_rdata.first;
                head_wdata.last  = edges_reg;
                edges_next = edges_reg + EDGE_W'(1);
                rv_next    = 1'b0;
                e_next     = head_rdata.last;
                state_next = (head_rdata.last == NO_EDGE) ? S_RESP : S_ADD2;
            end
            S_ADD2: begin
                link_we    = 1'b1;
                link_waddr = e_reg[EIDX_W-1:0];
                link_wdata = edges_reg - EDGE_W'(1);
                state_next = S_RESP;
            end
            S_Q1: begin
                ca_next    = info_rdata.comp;
                info_raddr = b_reg;
                state_next = S_Q2;
            end
            S_Q2: begin
                cb_next    = info_rdata.comp;
                same_next  = (ca_reg == info_rdata.comp);
                state_next = S_RESP;
            end
            S_CLR: begin
                info_we    = 1'b1;
                info_waddr = idx_reg[NODE_W-1:0];
                info_wdata = '0;
                idx_next   = idx_reg + CNT_W'(1);
                if (idx_reg == nc_reg - CNT_W'(1)) begin
                    idx_next   = '0;
                    vcnt_next  = '0;
                    ccnt_next  = '0;
                    pt_next    = '0;
                    ft_next    = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (idx_reg == nc_reg) begin
                    rv_next    = 1'b1;
                    state_next = S_RESP;
                end else begin
                    info_raddr = idx_reg[NODE_W-1:0];
                    state_next = S_ROOTW;
                end
            end
            S_ROOTW: begin
                if (info_rdata.visited) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_ROOT;
                end else begin
                    n_next     = idx_reg[NODE_W-1:0];
                    state_next = S_ENTER;
                end
            end
            S_ENTER: begin
                if (ft_reg != '0) begin
                    frame_we    = 1'b1;
                    frame_waddr = NODE_W'(ft_reg - CNT_W'(1));
                    frame_wdata = '{node: v_reg, edge_ptr: e_reg, low: vlow_reg,
                                    visit: vvis_reg};
                end
                head_raddr = n_reg;
                vcnt_next  = vc1;
                info_we    = 1'b1;
                info_waddr = n_reg;
                info_wdata = '{visited: 1'b1, onstk: 1'b1, visit: vc1, comp: '0};
                pend_we    = 1'b1;
                pend_waddr = pt_reg[NODE_W-1:0];
                pend_wdata = n_reg;
                pt_next    = pt_reg + CNT_W'(1);
                ft_next    = ft_reg + CNT_W'(1);
                v_next     = n_reg;
                vlow_next  = vc1;
                vvis_next  = vc1;
                state_next = S_ENTER1;
            end
            S_ENTER1: begin
                e_next     = head_rdata.first;
                state_next = S_LOOP;
            end
            S_LOOP: begin
                if (e_reg < NO_EDGE) begin
                    tgt_raddr  = e_reg[EIDX_W-1:0];
                    link_raddr = e_reg[EIDX_W-1:0];
                    state_next = S_EDGE1;
                end else begin
                    state_next = S_RET;
                end
            end
            S_EDGE1: begin
                e_next = link_rdata;
                if ({1'b0, tgt_rdata} >= nc_reg) begin
                    state_next = S_LOOP;
                end else begin
                    info_raddr = tgt_rdata;
                    n_next     = tgt_rdata;
                    state_next = S_EDGE2;
                end
            end
            S_EDGE2: begin
                if (!info_rdata.visited) begin
                    state_next = S_ENTER;
                end else begin
                    if (info_rdata.onstk && info_rdata.visit < vlow_reg) begin
                        vlow_next = info_rdata.visit;
                    end
                    state_next = S_LOOP;
                end
            end
            S_RET: begin
                if (vlow_reg == vvis_reg) begin
                    ccnt_next  = ccnt_reg + CNT_W'(1);
                    state_next = S_CLOSE0;
                end else begin
                    state_next = S_POP;
                end
            end
            S_CLOSE0: begin
                pend_raddr = NODE_W'(pt_reg - CNT_W'(1));
                pt_next    = pt_reg - CNT_W'(1);
                state_next = S_CLOSE1;
            end
            S_CLOSE1: begin
                info_we    = 1'b1;
                info_waddr = pend_rdata;
                info_wdata = '{visited: 1'b1, onstk: 1'b0, visit: '0, comp: ccnt_reg};
                state_next = (pend_rdata == v_reg) ? S_POP : S_CLOSE0;
            end
            S_POP: begin
                ft_next = ft_reg - CNT_W'(1);
                if (ft_reg == CNT_W'(1)) begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_ROOT;
                end else begin
                    frame_raddr = NODE_W'(ft_reg - CNT_W'(2));
                    state_next  = S_POP1;
                end
            end
            S_POP1: begin
                v_next     = frame_rdata.node;
                e_next     = frame_rdata.edge_ptr;
                vvis_next  = frame_rdata.visit;
                vlow_next  = (vlow_reg < frame_rdata.low) ? vlow_reg : frame_rdata.low;
                state_next = S_LOOP;
            end
            S_RESP: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            if (cfg_data == '0) begin
                nc_next = CNT_W'(1);
            end else if (cfg_data > CNT_W'(MAX_NODES)) begin
                nc_next = CNT_W'(MAX_NODES);
            end else begin
                nc_next = cfg_data;
            end
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            nc_reg    <= CNT_W'(MAX_NODES);
            edges_reg <= '0;
            vcnt_reg  <= '0;
            ccnt_reg  <= '0;
            rv_reg    <= 1'b0;
            pt_reg    <= '0;
            ft_reg    <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            nc_reg    <= nc_next;
            edges_reg <= edges_next;
            vcnt_reg  <= vcnt_next;
            ccnt_reg  <= ccnt_next;
            rv_reg    <= rv_next;
            pt_reg    <= pt_next;
            ft_reg    <= ft_next;
        end
        v_reg      <= v_next;
        e_reg      <= e_next;
        vlow_reg   <= vlow_next;
        vvis_reg   <= vvis_next;
        n_reg      <= n_next;
        b_reg      <= b_next;
        status_reg <= status_next;
        same_reg   <= same_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
    end

    `SCC_ASSERT(a_idle_stacks_empty, (state_reg == S_IDLE) |-> (ft_reg == '0 && pt_reg == '0))
    `SCC_ASSERT(a_edges_bounded, edges_reg <= NO_EDGE)
    `SCC_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != S_IDLE)

endmodule

@@ sv/strongly_connected_components.sv @@
// Strongly connected components engine.
// Input channel s_valid/s_ready/s_data carries one command word: add an edge,
// compute the components, or query a pair of nodes. Every command gives exactly
// one result word on m_valid/m_ready/m_data, held in an output register.
// The cfg_valid/cfg_ready/cfg_data channel sets the number of nodes in use; it is
// always ready and must only be written while the engine is idle.
// A stored edge updates its head entry and, if the node had edges, the old last link;
// a successful query reads both nodes' components; a rejected or unused command goes
// straight to its result. The head and node tables each give one read per cycle.
// A compute first clears node_count entries of the node table, one per cycle,
// then runs a depth-first walk over the nodes in use and their edges, and each
// node is written with its component number when its component is closed.
// Commands are handled one at a time: the next word is taken no earlier than the
// cycle in which the previous result word leaves the output register.
// After reset the engine sweeps the 1024-entry edge-list head table, one entry
// per cycle, and accepts no command until the sweep is done.
// A new command is accepted only when the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds off the input channel.
module strongly_connected_components (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [scc_pkg::CNT_W-1:0]  cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  scc_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output scc_pkg::out_t              m_data
);
    import scc_pkg::*;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic out_free;
    logic res_valid;
    out_t res_data;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    scc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule
